FILE: hw/rtl/cvio_pkg.sv
// Shared types and constants of the character video and I/O logic.
package cvio_pkg;

	localparam int FONT_ENTRIES  = 512;
	localparam int DISPLAY_LINES = 192;
	localparam int TEXT_COLUMNS  = 32;
	localparam int FONT_IDX_W    = $clog2(FONT_ENTRIES);

	localparam logic [2:0] CMD_FETCH     = 3'd0;
	localparam logic [2:0] CMD_PORT_RD   = 3'd1;
	localparam logic [2:0] CMD_PORT_WR   = 3'd2;
	localparam logic [2:0] CMD_SCANLINE  = 3'd3;
	localparam logic [2:0] CMD_KEY       = 3'd4;
	localparam logic [2:0] CMD_FONT_WR   = 3'd5;

	localparam logic [7:0] PORT_NMI_OFF  = 8'hFD;
	localparam logic [7:0] PORT_NMI_ON   = 8'hFE;
	localparam logic [7:0] OPCODE_NOP    = 8'h00;

	localparam logic       REG_INVERSE   = 1'b0;
	localparam logic       REG_REFRESH   = 1'b1;

	typedef struct packed {
		logic                  wr_en;
		logic                  rd_en;
		logic [FONT_IDX_W-1:0] addr;
		logic [7:0]            wdata;
	} font_req_t;

	typedef struct packed {
		logic [7:0] opcode_out;
		logic [7:0] read_data;
		logic       pixel_valid;
		logic       invert;
		logic [4:0] pixel_column;
		logic [7:0] pixel_line;
		logic       irq_request;
		logic [7:0] irq_delay;
		logic       nmi_request;
	} stage_t;

endpackage

FILE: hw/rtl/cvio_font_ram.sv
// Font store: single-port memory with registered read data.
module cvio_font_ram (
	input  logic                clk,
	input  cvio_pkg::font_req_t req,
	output logic [7:0]          rd_data
);

	logic [7:0] mem [cvio_pkg::FONT_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.addr];
		end
	end

endmodule

FILE: hw/rtl/char_video_and_io_logic.sv
// Top level of the character video and I/O logic.
// Input channel (in_valid/in_stall) carries one bus item: command, address,
// data_byte, key fields and tape_in. Every item returns exactly one result item
// on the output channel (out_valid/out_stall) carrying opcode, port read data,
// one pixel row, interrupt request and delay, and the NMI request.
// A result passes through one stage holding the font read and then one result
// register. Throughput: one item per cycle while the receiver does not stall;
// internal state (line, row, column, NMI enable, keyboard) is updated at the
// accepting edge, and the font store is read or written in that same edge
// through its single port.
// When the receiver stalls, the result register holds, the middle stage fills,
// and in_stall rises only once both are occupied; no item is lost.
// Reset clears both stages, the counters and the keyboard matrix (no key
// pressed), sets NMI and line counting enabled, inverse_video to 0 and
// refresh_50hz to 1. The font store is not cleared and must be written before
// characters are displayed.
// Configuration: APB port, inverse_video at 0x0, refresh_50hz at 0x4; write
// only while the block is idle.
module char_video_and_io_logic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  key_row,
	input  logic [2:0]  key_column,
	input  logic        key_down,
	input  logic        tape_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  opcode_out,
	output logic [7:0]  read_data,
	output logic        pixel_valid,
	output logic [7:0]  pixel_bits,
	output logic [4:0]  pixel_column,
	output logic [7:0]  pixel_line,
	output logic        irq_request,
	output logic [7:0]  irq_delay,
	output logic        nmi_request
);

	logic inverse_video_q, refresh_50hz_q;
	logic [7:0] line_counter_q, line_counter_d;
	logic [2:0] char_row_q, char_row_d;
	logic [5:0] column_q, column_d;
	logic lce_q, lce_d;
	logic nmi_en_q, nmi_en_d;
	logic [4:0] key_matrix_q [8];
	logic [4:0] key_row_d;

	logic accept, s1_adv, cfg_wr;
	logic s1_valid_s1;
	cvio_pkg::stage_t st_d, st_s1;
	cvio_pkg::font_req_t font_req;
	logic [7:0] font_data;
	logic [4:0] keys;
	logic [5:0] irq_diff;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = {31'd0, (paddr[2] == cvio_pkg::REG_REFRESH) ? refresh_50hz_q
						: inverse_video_q};
	assign s1_adv   = s1_valid_s1 && (!out_valid || !out_stall);
	assign in_stall = s1_valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_video_q <= 1'b0;
			refresh_50hz_q  <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == cvio_pkg::REG_REFRESH) begin
				refresh_50hz_q <= pwdata[0];
			end else begin
				inverse_video_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		keys = 5'h1F;
		for (int r = 0; r < 8; r++) begin
			if (!address[8 + r]) begin
				keys = keys & key_matrix_q[r];
			end
		end
	end

	assign irq_diff = 6'(7'(cvio_pkg::TEXT_COLUMNS) - {1'b0, column_q});

	always_comb begin
		line_counter_d = line_counter_q;
		char_row_d     = char_row_q;
		column_d       = column_q;
		lce_d          = lce_q;
		nmi_en_d       = nmi_en_q;
		key_row_d      = key_matrix_q[key_row];
		st_d           = '0;
		font_req.wr_en = 1'b0;
		font_req.rd_en = 1'b0;
		font_req.addr  = cvio_pkg::FONT_IDX_W'({data_byte[5:0], char_row_q});
		font_req.wdata = data_byte;
		case (command)
			cvio_pkg::CMD_FETCH: begin
				if (!address[15]) begin
					st_d.opcode_out = data_byte;
				end else if (!data_byte[6]) begin
					st_d.opcode_out = cvio_pkg::OPCODE_NOP;
					if (line_counter_q < 8'(cvio_pkg::DISPLAY_LINES) &&
							column_q < 6'(cvio_pkg::TEXT_COLUMNS)) begin
						font_req.rd_en     = 1'b1;
						st_d.pixel_valid   = 1'b1;
						st_d.invert        = inverse_video_q ^ data_byte[7];
						st_d.pixel_column  = column_q[4:0];
						st_d.pixel_line    = line_counter_q;
						column_d           = column_q + 6'd1;
					end
				end else begin
					st_d.opcode_out  = data_byte;
					st_d.irq_request = 1'b1;
					if (column_q != 6'd0) begin
						st_d.irq_delay = {irq_diff, 2'b00};
						column_d       = 6'd0;
						char_row_d     = char_row_q + 3'd1;
						if (lce_q && line_counter_q != 8'hFF) begin
							line_counter_d = line_counter_q + 8'd1;
						end
					end else begin
						char_row_d = 3'd0;
					end
				end
			end
			cvio_pkg::CMD_PORT_RD: begin
				if (!address[0]) begin
					if (!nmi_en_q) begin
						line_counter_d = 8'd0;
						lce_d          = 1'b0;
					end
					st_d.read_data = {lce_d ? 1'b0 : tape_in, refresh_50hz_q, 1'b1, keys};
				end
			end
			cvio_pkg::CMD_PORT_WR: begin
				lce_d = 1'b1;
				if (address[7:0] == cvio_pkg::PORT_NMI_OFF) begin
					nmi_en_d = 1'b0;
				end else if (address[7:0] == cvio_pkg::PORT_NMI_ON) begin
					nmi_en_d = 1'b1;
				end
			end
			cvio_pkg::CMD_SCANLINE: begin
				st_d.nmi_request = nmi_en_q;
			end
			cvio_pkg::CMD_KEY: begin
				if (key_column < 3'd5) begin
					key_row_d[key_column] = !key_down;
				end
			end
			cvio_pkg::CMD_FONT_WR: begin
				font_req.addr = address[cvio_pkg::FONT_IDX_W-1:0];
				if (address < 16'(cvio_pkg::FONT_ENTRIES)) begin
					font_req.wr_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			font_req.wr_en = 1'b0;
			font_req.rd_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_counter_q <= 8'd0;
			char_row_q     <= 3'd0;
			column_q       <= 6'd0;
			lce_q          <= 1'b1;
			nmi_en_q       <= 1'b1;
			for (int r = 0; r < 8; r++) begin
				key_matrix_q[r] <= 5'h1F;
			end
		end else if (accept) begin
			line_counter_q         <= line_counter_d;
			char_row_q             <= char_row_d;
			column_q               <= column_d;
			lce_q                  <= lce_d;
			nmi_en_q               <= nmi_en_d;
			key_matrix_q[key_row]  <= key_row_d;
		end
	end

	cvio_font_ram u_font (
		.clk     (clk),
		.req     (font_req),
		.rd_data (font_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1 <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			opcode_out   <= st_s1.opcode_out;
			read_data    <= st_s1.read_data;
			pixel_valid  <= st_s1.pixel_valid;
			pixel_bits   <= st_s1.pixel_valid ? (font_data ^ {8{st_s1.invert}}) : 8'd0;
			pixel_column <= st_s1.pixel_column;
			pixel_line   <= st_s1.pixel_line;
			irq_request  <= st_s1.irq_request;
			irq_delay    <= st_s1.irq_delay;
			nmi_request  <= st_s1.nmi_request;
		end
	end

	a_column_sat: assert property (@(posedge clk) disable iff (!arst_n)
		column_q <= 6'(cvio_pkg::TEXT_COLUMNS))
		else $error("column count beyond text width");

	a_line_held: assert property (@(posedge clk) disable iff (!arst_n)
		!lce_q |-> line_counter_q == 8'd0)
		else $error("line counter moved while counting disabled");

	a_pixel_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> pixel_line < 8'(cvio_pkg::DISPLAY_LINES)
			&& opcode_out == cvio_pkg::OPCODE_NOP)
		else $error("pixel row outside display or opcode not NOP");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1 && out_valid && out_stall)
		else $error("input stalled with free pipeline space");

endmodule
